// ----- rtl/wss_pkg.sv -----
// Shared types and constants for the waypoint seek steering block.
// Used by every module under rtl; depends on nothing else.
`default_nettype none

package wss_pkg;

    // Default sizes of the route store
    localparam int ROUTES_DEF = 16;
    localparam int PPR_DEF    = 256;
    // Widest store address: 256 routes of 4096 points
    localparam int ADDR_W     = 20;

    // Pipeline depths of the square root and divider units
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 20;

    localparam logic [31:0] THR_RESET  = 32'd65536000;
    localparam logic [15:0] GAIN_RESET = 16'd1280;

    typedef enum logic [1:0] {
        REQ_VEHICLE = 2'd0,
        REQ_LOAD_WP = 2'd1,
        REQ_SET_LEN = 2'd2
    } req_t;

    // Command passed from the front end to the back end
    typedef struct packed {
        logic                is_load;
        logic                skip;
        logic [7:0]          idx;
        logic [7:0]          nidx;
        logic [ADDR_W-1:0]   addr_cur;
        logic [ADDR_W-1:0]   addr_nxt;
        logic signed [23:0]  pos_x;
        logic signed [23:0]  pos_y;
        logic signed [19:0]  vel_x;
        logic signed [19:0]  vel_y;
        logic [18:0]         speed;
        logic signed [23:0]  wp_x;
        logic signed [23:0]  wp_y;
    } cmd_t;

    // Per-item data carried alongside the square root and divider
    typedef struct packed {
        logic                skip;
        logic                adv;
        logic                zero;
        logic                neg_x;
        logic                neg_y;
        logic [7:0]          idx;
        logic signed [19:0]  vel_x;
        logic signed [19:0]  vel_y;
    } side_t;

endpackage

`default_nettype wire

// ----- rtl/wss_front.sv -----
// Front end: accepts input items, keeps the route length table, checks
// routes and indices and builds store commands. Depends on wss_pkg.
`default_nettype none

module wss_front
    import wss_pkg::*;
#(
    parameter int ROUTES           = ROUTES_DEF,
    parameter int POINTS_PER_ROUTE = PPR_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [183:0] s_tdata,  // is_driving, route_index, waypoint_index, pos_x, pos_y,
                                        // vel_x, vel_y, cruise_speed, wp_x, wp_y, route_length
    input  wire logic [1:0]   s_tuser,  // req_type
    input  wire logic         full,
    output logic              push,
    output cmd_t              cmd
);

    localparam int RIW = (ROUTES > 1) ? $clog2(ROUTES) : 1;

    logic [8:0]  len_reg [0:ROUTES-1];

    logic        accept;
    logic        drv;
    logic [7:0]  route8;
    logic [7:0]  wpi;
    logic [8:0]  rlen_in;
    logic        route_ok;
    logic        load_ok;
    logic [8:0]  len_rd;
    logic [8:0]  len_clip;
    logic [8:0]  idx9;
    logic [8:0]  inc9;
    logic [8:0]  nidx9;
    logic [31:0] base;
    logic [31:0] addr_cur;
    logic [31:0] addr_nxt;
    logic        set_len;
    logic        is_load;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    assign drv     = s_tdata[0];
    assign route8  = {4'b0, s_tdata[4:1]};
    assign wpi     = s_tdata[12:5];
    assign rlen_in = s_tdata[176:168];

    // Check route and look up its length
    assign route_ok = ({24'b0, route8} < 32'(ROUTES));
    assign load_ok  = route_ok && ({24'b0, wpi} < 32'(POINTS_PER_ROUTE));
    assign len_rd   = route_ok ? len_reg[route8[RIW-1:0]] : 9'd0;
    assign len_clip = ({23'b0, rlen_in} > 32'(POINTS_PER_ROUTE)) ?
                      9'(POINTS_PER_ROUTE) : rlen_in;

    // Next target with wrap at the route length
    assign idx9  = {1'b0, wpi};
    assign inc9  = idx9 + 9'd1;
    assign nidx9 = (inc9 == len_rd) ? 9'd0 : inc9;

    // Store addresses of current and next target
    assign base     = {24'b0, route8} * 32'(POINTS_PER_ROUTE);
    assign addr_cur = base + {24'b0, wpi};
    assign addr_nxt = base + {23'b0, nidx9};

    // Classify the item
    always_comb
    begin
        push    = 1'b0;
        set_len = 1'b0;
        is_load = 1'b0;
        case (req_t'(s_tuser))
            REQ_VEHICLE:
            begin
                push = accept;
            end
            REQ_LOAD_WP:
            begin
                push    = accept && load_ok;
                is_load = 1'b1;
            end
            REQ_SET_LEN:
            begin
                set_len = accept && route_ok;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    assign cmd.is_load  = is_load;
    assign cmd.skip     = !drv || (len_rd == 9'd0) || (idx9 >= len_rd);
    assign cmd.idx      = wpi;
    assign cmd.nidx     = nidx9[7:0];
    assign cmd.addr_cur = addr_cur[ADDR_W-1:0];
    assign cmd.addr_nxt = addr_nxt[ADDR_W-1:0];
    assign cmd.pos_x    = s_tdata[36:13];
    assign cmd.pos_y    = s_tdata[60:37];
    assign cmd.vel_x    = s_tdata[80:61];
    assign cmd.vel_y    = s_tdata[100:81];
    assign cmd.speed    = s_tdata[119:101];
    assign cmd.wp_x     = s_tdata[143:120];
    assign cmd.wp_y     = s_tdata[167:144];

    // Hold route lengths; reset empties every route
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROUTES; i++)
            begin
                len_reg[i] <= 9'd0;
            end
        end
        else if (set_len)
        begin
            len_reg[route8[RIW-1:0]] <= len_clip;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/wss_fifo.sv -----
// Four-entry command queue between the front end and the back end.
// Depends on wss_pkg for the command type.
`default_nettype none

module wss_fifo
    import wss_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      din,
    input  wire logic pop,
    output cmd_t      dout,
    output logic      full,
    output logic      empty
);

    cmd_t       mem [0:3];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;

    assign full  = (cnt_reg == 3'd4);
    assign empty = (cnt_reg == 3'd0);
    assign dout  = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 3'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 3'd1;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            cnt_reg    <= 3'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/wss_isqrt.sv -----
// Pipelined integer square root, one root bit per stage, floor result.
// Depends on wss_pkg for the stage count.
`default_nettype none

module wss_isqrt
    import wss_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        ce,
    input  wire logic [63:0] radicand,
    output logic [31:0]      root
);

    logic [32:0] rem_reg  [0:SQRT_STAGES-1];
    logic [31:0] root_reg [0:SQRT_STAGES-1];
    logic [63:0] n_reg    [0:SQRT_STAGES-1];

    genvar gi;
    for (gi = 0; gi < SQRT_STAGES; gi++)
    begin : g_stage
        logic [32:0] rem_prev;
        logic [31:0] root_prev;
        logic [63:0] n_prev;
        logic [34:0] cur;
        logic [34:0] trial;
        logic        ge;

        if (gi == 0)
        begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign n_prev    = radicand;
        end
        else
        begin : g_rest
            assign rem_prev  = rem_reg[gi-1];
            assign root_prev = root_reg[gi-1];
            assign n_prev    = n_reg[gi-1];
        end

        // Bring down two bits and try root*4+1
        assign cur   = {rem_prev, n_prev[63:62]};
        assign trial = {1'b0, root_prev, 2'b01};
        assign ge    = (cur >= trial);

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[gi]  <= ge ? 33'(cur - trial) : cur[32:0];
                root_reg[gi] <= {root_prev[30:0], ge};
                n_reg[gi]    <= {n_prev[61:0], 2'b00};
            end
        end
    end

    assign root = root_reg[SQRT_STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/wss_back.sv -----
// Back end: waypoint store, distance, reach test, square root, divide,
// steering gain and saturation. Depends on wss_pkg and wss_isqrt.
`default_nettype none

module wss_back
    import wss_pkg::*;
#(
    parameter int ROUTES           = ROUTES_DEF,
    parameter int POINTS_PER_ROUTE = PPR_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        empty,
    input  cmd_t             cmd,
    output logic             pop,
    input  wire logic [31:0] thr,
    input  wire logic [15:0] gain,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,  // accel_x, accel_y, next_waypoint
    output logic [1:0]       m_tuser   // advanced, skipped
);

    localparam int DEPTH = ROUTES * POINTS_PER_ROUTE;
    localparam int AW    = $clog2(DEPTH);
    localparam int DL    = SQRT_STAGES;

    logic ce;

    // Waypoint store and stage A
    logic signed [23:0] wpx_mem [0:DEPTH-1];
    logic signed [23:0] wpy_mem [0:DEPTH-1];
    logic signed [23:0] rdx0_reg, rdx1_reg, rdy0_reg, rdy1_reg;
    logic               a_vld_reg;
    cmd_t               a_cmd_reg;

    // Stage B: differences
    logic               b_vld_reg;
    cmd_t               b_cmd_reg;
    logic signed [24:0] dx0_reg, dy0_reg, dx1_reg, dy1_reg;

    // Stage C: squares
    logic               c_vld_reg;
    cmd_t               c_cmd_reg;
    logic signed [24:0] c_dx0_reg, c_dy0_reg, c_dx1_reg, c_dy1_reg;
    logic [48:0]        sqx0_reg, sqy0_reg, sqx1_reg, sqy1_reg;
    logic signed [49:0] px0, py0, px1, py1;

    // Stage D: squared distances
    logic               d_vld_reg;
    cmd_t               d_cmd_reg;
    logic signed [24:0] d_dx0_reg, d_dy0_reg, d_dx1_reg, d_dy1_reg;
    logic [49:0]        dsq0_reg, dsq1_reg;

    // Stage E: reach test and target select
    logic               e_vld_reg;
    cmd_t               e_cmd_reg;
    logic               e_adv_reg;
    logic [7:0]         e_idx_reg;
    logic signed [24:0] e_dx_reg, e_dy_reg;
    logic [49:0]        e_dsq_reg;
    logic               reached;

    // Stage F: numerators and radicand
    logic               f_vld_reg;
    side_t              f_side_reg;
    logic [42:0]        f_numx_reg, f_numy_reg;
    logic [63:0]        f_rad_reg;
    logic [23:0]        magx, magy;

    // Delay beside the square root
    logic               dl_vld_reg  [0:DL-1];
    side_t              dl_side_reg [0:DL-1];
    logic [42:0]        dl_numx_reg [0:DL-1];
    logic [42:0]        dl_numy_reg [0:DL-1];
    logic [31:0]        root;

    // Divider stages
    logic               dv_vld_reg  [0:DIV_STAGES-1];
    side_t              dv_side_reg [0:DIV_STAGES-1];
    logic [32:0]        dv_rx_reg   [0:DIV_STAGES-1];
    logic [32:0]        dv_ry_reg   [0:DIV_STAGES-1];
    logic [19:0]        dv_qx_reg   [0:DIV_STAGES-1];
    logic [19:0]        dv_qy_reg   [0:DIV_STAGES-1];
    logic [49:0]        dv_nx_reg   [0:DIV_STAGES-1];
    logic [49:0]        dv_ny_reg   [0:DIV_STAGES-1];
    logic [31:0]        dv_d_reg    [0:DIV_STAGES-1];

    // Stage G: gain product
    logic               g_vld_reg;
    side_t              g_side_reg;
    logic signed [38:0] g_px_reg, g_py_reg;
    side_t              lside;
    logic [19:0]        lqx, lqy;
    logic signed [20:0] dvx, dvy;
    logic signed [21:0] difx, dify;

    // Output register
    logic               out_vld_reg;
    logic [23:0]        ax_reg, ay_reg;
    logic [7:0]         nwp_reg;
    logic               adv_reg, skip_reg;
    logic [23:0]        satx, saty;

    function automatic logic signed [49:0] c_mul(input logic signed [24:0] v);
        c_mul = v * v;
    endfunction

    // Divide by 256 toward zero, then clamp to 24 bits
    function automatic logic [23:0] sat_q(input logic signed [38:0] p);
        logic signed [38:0] adj;
        logic signed [38:0] sh;
        adj = p + (p[38] ? 39'sd255 : 39'sd0);
        sh  = adj >>> 8;
        if (sh > 39'sd8388607)
        begin
            sat_q = 24'h7FFFFF;
        end
        else if (sh < -39'sd8388608)
        begin
            sat_q = 24'h800000;
        end
        else
        begin
            sat_q = sh[23:0];
        end
    endfunction

    assign ce  = !out_vld_reg || m_tready;
    assign pop = ce && !empty;

    // Write loads and read both candidate targets
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            if (!empty && cmd.is_load)
            begin
                wpx_mem[cmd.addr_cur[AW-1:0]] <= cmd.wp_x;
            end
            rdx0_reg <= wpx_mem[cmd.addr_cur[AW-1:0]];
            rdx1_reg <= wpx_mem[cmd.addr_nxt[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            if (!empty && cmd.is_load)
            begin
                wpy_mem[cmd.addr_cur[AW-1:0]] <= cmd.wp_y;
            end
            rdy0_reg <= wpy_mem[cmd.addr_cur[AW-1:0]];
            rdy1_reg <= wpy_mem[cmd.addr_nxt[AW-1:0]];
        end
    end

    assign px0 = c_mul(dx0_reg);
    assign py0 = c_mul(dy0_reg);
    assign px1 = c_mul(dx1_reg);
    assign py1 = c_mul(dy1_reg);

    assign reached = (dsq0_reg < {18'b0, thr});

    assign magx = e_dx_reg[24] ? 24'(-e_dx_reg) : e_dx_reg[23:0];
    assign magy = e_dy_reg[24] ? 24'(-e_dy_reg) : e_dy_reg[23:0];

    // Stages A to F payload
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            a_cmd_reg <= cmd;

            b_cmd_reg <= a_cmd_reg;
            dx0_reg   <= {rdx0_reg[23], rdx0_reg} - {a_cmd_reg.pos_x[23], a_cmd_reg.pos_x};
            dy0_reg   <= {rdy0_reg[23], rdy0_reg} - {a_cmd_reg.pos_y[23], a_cmd_reg.pos_y};
            dx1_reg   <= {rdx1_reg[23], rdx1_reg} - {a_cmd_reg.pos_x[23], a_cmd_reg.pos_x};
            dy1_reg   <= {rdy1_reg[23], rdy1_reg} - {a_cmd_reg.pos_y[23], a_cmd_reg.pos_y};

            c_cmd_reg <= b_cmd_reg;
            c_dx0_reg <= dx0_reg;
            c_dy0_reg <= dy0_reg;
            c_dx1_reg <= dx1_reg;
            c_dy1_reg <= dy1_reg;
            sqx0_reg  <= px0[48:0];
            sqy0_reg  <= py0[48:0];
            sqx1_reg  <= px1[48:0];
            sqy1_reg  <= py1[48:0];

            d_cmd_reg <= c_cmd_reg;
            d_dx0_reg <= c_dx0_reg;
            d_dy0_reg <= c_dy0_reg;
            d_dx1_reg <= c_dx1_reg;
            d_dy1_reg <= c_dy1_reg;
            dsq0_reg  <= {1'b0, sqx0_reg} + {1'b0, sqy0_reg};
            dsq1_reg  <= {1'b0, sqx1_reg} + {1'b0, sqy1_reg};

            // A skipped vehicle keeps its own index
            e_cmd_reg <= d_cmd_reg;
            e_adv_reg <= reached;
            e_idx_reg <= (reached && !d_cmd_reg.skip) ? d_cmd_reg.nidx : d_cmd_reg.idx;
            e_dx_reg  <= reached ? d_dx1_reg : d_dx0_reg;
            e_dy_reg  <= reached ? d_dy1_reg : d_dy0_reg;
            e_dsq_reg <= reached ? dsq1_reg : dsq0_reg;

            f_side_reg.skip  <= e_cmd_reg.skip;
            f_side_reg.adv   <= e_adv_reg;
            f_side_reg.zero  <= (e_dsq_reg == 50'd0);
            f_side_reg.neg_x <= e_dx_reg[24];
            f_side_reg.neg_y <= e_dy_reg[24];
            f_side_reg.idx   <= e_idx_reg;
            f_side_reg.vel_x <= e_cmd_reg.vel_x;
            f_side_reg.vel_y <= e_cmd_reg.vel_y;
            f_numx_reg       <= magx * e_cmd_reg.speed;
            f_numy_reg       <= magy * e_cmd_reg.speed;
            f_rad_reg        <= {e_dsq_reg, 14'b0};
        end
    end

    wss_isqrt u_isqrt (
        .clk      (clk),
        .ce       (ce),
        .radicand (f_rad_reg),
        .root     (root)
    );

    // Hold item data beside the square root
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            dl_side_reg[0] <= f_side_reg;
            dl_numx_reg[0] <= f_numx_reg;
            dl_numy_reg[0] <= f_numy_reg;
            for (int i = 1; i < DL; i++)
            begin
                dl_side_reg[i] <= dl_side_reg[i-1];
                dl_numx_reg[i] <= dl_numx_reg[i-1];
                dl_numy_reg[i] <= dl_numy_reg[i-1];
            end
        end
    end

    // Divider: quotient below 2^20, one bit per stage
    genvar gj;
    for (gj = 0; gj < DIV_STAGES; gj++)
    begin : g_div
        logic [32:0] rx_prev, ry_prev;
        logic [19:0] qx_prev, qy_prev;
        logic [49:0] nx_prev, ny_prev;
        logic [31:0] d_prev;
        side_t       s_prev;
        logic [33:0] curx, cury;
        logic        gex, gey;

        if (gj == 0)
        begin : g_first
            assign nx_prev = {dl_numx_reg[DL-1], 7'b0};
            assign ny_prev = {dl_numy_reg[DL-1], 7'b0};
            assign rx_prev = {3'b0, nx_prev[49:20]};
            assign ry_prev = {3'b0, ny_prev[49:20]};
            assign qx_prev = '0;
            assign qy_prev = '0;
            assign d_prev  = root;
            assign s_prev  = dl_side_reg[DL-1];
        end
        else
        begin : g_rest
            assign nx_prev = dv_nx_reg[gj-1];
            assign ny_prev = dv_ny_reg[gj-1];
            assign rx_prev = dv_rx_reg[gj-1];
            assign ry_prev = dv_ry_reg[gj-1];
            assign qx_prev = dv_qx_reg[gj-1];
            assign qy_prev = dv_qy_reg[gj-1];
            assign d_prev  = dv_d_reg[gj-1];
            assign s_prev  = dv_side_reg[gj-1];
        end

        assign curx = {rx_prev, nx_prev[DIV_STAGES-1-gj]};
        assign cury = {ry_prev, ny_prev[DIV_STAGES-1-gj]};
        assign gex  = (curx >= {2'b0, d_prev});
        assign gey  = (cury >= {2'b0, d_prev});

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                dv_rx_reg[gj]   <= gex ? 33'(curx - {2'b0, d_prev}) : curx[32:0];
                dv_ry_reg[gj]   <= gey ? 33'(cury - {2'b0, d_prev}) : cury[32:0];
                dv_qx_reg[gj]   <= {qx_prev[18:0], gex};
                dv_qy_reg[gj]   <= {qy_prev[18:0], gey};
                dv_nx_reg[gj]   <= nx_prev;
                dv_ny_reg[gj]   <= ny_prev;
                dv_d_reg[gj]    <= d_prev;
                dv_side_reg[gj] <= s_prev;
            end
        end
    end

    // Signed desired velocity minus current velocity
    assign lside = dv_side_reg[DIV_STAGES-1];
    assign lqx   = dv_qx_reg[DIV_STAGES-1];
    assign lqy   = dv_qy_reg[DIV_STAGES-1];
    assign dvx   = lside.zero ? 21'sd0 :
                   (lside.neg_x ? -$signed({1'b0, lqx}) : $signed({1'b0, lqx}));
    assign dvy   = lside.zero ? 21'sd0 :
                   (lside.neg_y ? -$signed({1'b0, lqy}) : $signed({1'b0, lqy}));
    assign difx  = {dvx[20], dvx} - {{2{lside.vel_x[19]}}, lside.vel_x};
    assign dify  = {dvy[20], dvy} - {{2{lside.vel_y[19]}}, lside.vel_y};

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            g_side_reg <= lside;
            g_px_reg   <= $signed({1'b0, gain}) * difx;
            g_py_reg   <= $signed({1'b0, gain}) * dify;
        end
    end

    assign satx = sat_q(g_px_reg);
    assign saty = sat_q(g_py_reg);

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            ax_reg   <= g_side_reg.skip ? 24'd0 : satx;
            ay_reg   <= g_side_reg.skip ? 24'd0 : saty;
            nwp_reg  <= g_side_reg.idx;
            adv_reg  <= g_side_reg.adv && !g_side_reg.skip;
            skip_reg <= g_side_reg.skip;
        end
    end

    // Advance valid bits along the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            d_vld_reg   <= 1'b0;
            e_vld_reg   <= 1'b0;
            f_vld_reg   <= 1'b0;
            g_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int i = 0; i < DL; i++)
            begin
                dl_vld_reg[i] <= 1'b0;
            end
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                dv_vld_reg[i] <= 1'b0;
            end
        end
        else if (ce)
        begin
            a_vld_reg     <= !empty && !cmd.is_load;
            b_vld_reg     <= a_vld_reg;
            c_vld_reg     <= b_vld_reg;
            d_vld_reg     <= c_vld_reg;
            e_vld_reg     <= d_vld_reg;
            f_vld_reg     <= e_vld_reg;
            dl_vld_reg[0] <= f_vld_reg;
            for (int i = 1; i < DL; i++)
            begin
                dl_vld_reg[i] <= dl_vld_reg[i-1];
            end
            dv_vld_reg[0] <= dl_vld_reg[DL-1];
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                dv_vld_reg[i] <= dv_vld_reg[i-1];
            end
            g_vld_reg   <= dv_vld_reg[DIV_STAGES-1];
            out_vld_reg <= g_vld_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {nwp_reg, ay_reg, ax_reg};
    assign m_tuser  = {skip_reg, adv_reg};

endmodule

`default_nettype wire

// ----- rtl/waypoint_seek_steering.sv -----
// Waypoint seek steering, top level: configuration registers and the
// front end, command queue and back end. Depends on wss_pkg and all wss_* modules.
//
// Usage:
//   Input stream (s_*): s_tuser selects the item kind: vehicle, waypoint load or
//   route length. Loads and length sets give no result; every vehicle item gives
//   exactly one result on the output stream (m_*), in input order.
//   Output: m_tdata holds accel_x, accel_y, next_waypoint; m_tuser holds advanced
//   and skipped. Skipped vehicles return zero acceleration and their own index.
//   Configuration: APB writes to reach_threshold_sq (0x0) and steer_gain (0x4),
//   only while no item is in flight. pready is tied high.
// Timing:
//   One item per cycle sustained while m_tready is high. A vehicle result passes
//   through the queue, store read, 5 distance and numerator stages, 32 square root
//   stages, 20 divider stages, the gain stage and the result register.
// Reset:
//   rst_n clears pipeline valids, the queue, the route length table (all routes
//   empty) and restores the register defaults. The waypoint store is not cleared.
// Stall:
//   When m_tready is low while a result is valid the whole back end holds; the
//   queue then fills and s_tready drops once it holds four commands.
`default_nettype none

module waypoint_seek_steering
    import wss_pkg::*;
#(
    parameter int ROUTES           = ROUTES_DEF,
    parameter int POINTS_PER_ROUTE = PPR_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [183:0] s_tdata,  // is_driving, route_index, waypoint_index, pos_x, pos_y,
                                        // vel_x, vel_y, cruise_speed, wp_x, wp_y, route_length
    input  wire logic [1:0]   s_tuser,  // req_type
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [55:0]       m_tdata,  // accel_x, accel_y, next_waypoint
    output logic [1:0]        m_tuser,  // advanced, skipped
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam logic REG_THR  = 1'b0;
    localparam logic REG_GAIN = 1'b1;

    logic [31:0] thr_reg;
    logic [15:0] gain_reg;
    logic        cfg_wr;

    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    cmd_t        cmd_in;
    cmd_t        cmd_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_RESET;
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_THR:  thr_reg  <= pwdata;
                REG_GAIN: gain_reg <= pwdata[15:0];
                default:  thr_reg  <= thr_reg;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (paddr[2])
            REG_THR:  prdata = thr_reg;
            REG_GAIN: prdata = {16'b0, gain_reg};
            default:  prdata = 32'd0;
        endcase
    end

    wss_front #(
        .ROUTES           (ROUTES),
        .POINTS_PER_ROUTE (POINTS_PER_ROUTE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .full     (full),
        .push     (push),
        .cmd      (cmd_in)
    );

    wss_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (cmd_in),
        .pop   (pop),
        .dout  (cmd_out),
        .full  (full),
        .empty (empty)
    );

    wss_back #(
        .ROUTES           (ROUTES),
        .POINTS_PER_ROUTE (POINTS_PER_ROUTE)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .cmd      (cmd_out),
        .pop      (pop),
        .thr      (thr_reg),
        .gain     (gain_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
